### rtl/wshc_pkg.sv
`timescale 1ns / 1ps
// Shared constants of the window size hint constrainer: register indexes,
// hint enable bit positions and fixed field widths. No dependencies.
package wshc_pkg;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 15;
    localparam int ADDR_W = 5;
    localparam int CFG_W  = 31;
    localparam int ENA_W  = 6;

    localparam int DEFAULT_MAX = 32767;
    localparam int OUT_MAX     = 32767;

    localparam logic [2:0] REG_HINT_EN  = 3'd0;
    localparam logic [2:0] REG_BASE     = 3'd1;
    localparam logic [2:0] REG_MIN      = 3'd2;
    localparam logic [2:0] REG_MAX      = 3'd3;
    localparam logic [2:0] REG_INC      = 3'd4;
    localparam logic [2:0] REG_MIN_ASP  = 3'd5;
    localparam logic [2:0] REG_MAX_ASP  = 3'd6;

    localparam int EN_BASE   = 0;
    localparam int EN_MIN    = 1;
    localparam int EN_MAX    = 2;
    localparam int EN_HINC   = 3;
    localparam int EN_VINC   = 4;
    localparam int EN_ASPECT = 5;

endpackage

### rtl/wshc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// word and a valid bit that travel alongside. No dependencies.
module wshc_div #(
    parameter int DW = 32,
    parameter int NW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quot,
    output logic [NW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic [NW-1:0] r_rem  [DW];
    logic [DW-1:0] r_acc  [DW];
    logic [NW-1:0] r_dvs  [DW];
    logic [SW-1:0] r_side [DW];
    logic [DW-1:0] r_vld;

    logic [NW-1:0] s_rem  [DW];
    logic [DW-1:0] s_acc  [DW];
    logic [NW-1:0] s_dvs  [DW];
    logic [SW-1:0] s_side [DW];
    logic [NW-1:0] n_rem  [DW];
    logic [DW-1:0] n_acc  [DW];

    for (genvar s = 0; s < DW; s++) begin : g_stage
        logic [NW:0] w_trial;
        logic        w_ge;
        if (s == 0) begin : g_first
            assign s_rem[s]  = '0;
            assign s_acc[s]  = i_dividend;
            assign s_dvs[s]  = i_divisor;
            assign s_side[s] = i_side;
        end else begin : g_next
            assign s_rem[s]  = r_rem[s-1];
            assign s_acc[s]  = r_acc[s-1];
            assign s_dvs[s]  = r_dvs[s-1];
            assign s_side[s] = r_side[s-1];
        end
        assign w_trial  = {s_rem[s], s_acc[s][DW-1]};
        assign w_ge     = w_trial >= {1'b0, s_dvs[s]};
        assign n_rem[s] = w_ge ? NW'(w_trial - {1'b0, s_dvs[s]}) : NW'(w_trial);
        assign n_acc[s] = {s_acc[s][DW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DW; s++) begin
                r_rem[s]  <= n_rem[s];
                r_acc[s]  <= n_acc[s];
                r_dvs[s]  <= s_dvs[s];
                r_side[s] <= s_side[s];
            end
        end
    end

    assign o_valid = r_vld[DW-1];
    assign o_quot  = r_acc[DW-1];
    assign o_rem   = r_rem[DW-1];
    assign o_side  = r_side[DW-1];

endmodule

### rtl/window_size_hint_constrainer_unit.sv
`timescale 1ns / 1ps
// Top level of the window size hint constrainer: register file, clamp, snap
// and aspect pipeline. Depends on wshc_pkg and wshc_div.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: request width, request height
//  m_axis    out  tvalid/tready          tdata: granted width, granted height
//  apb       in   psel/penable/pready    paddr, pwdata, prdata (7 registers)
//
// One word enters per cycle while the output is not stalled; the latency is set by
// the ten bit-per-stage dividers in the chain.
// Reset clears the hint registers and all valid bits. A stall at the output freezes
// every stage at once, so nothing is lost or repeated.
module window_size_hint_constrainer_unit
    import wshc_pkg::*;
#(
    parameter int SIZE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // Bits 15:0 request_width, bits 31:16 request_height.
    input  logic [31:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // Bits 14:0 granted_width, bits 29:15 granted_height, bits 31:30 zero.
    output logic [31:0]       m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SB   = SIZE_BITS;
    localparam int HB   = CFG_W - SB;
    localparam int PW   = (SB > HB) ? SB : HB;
    localparam int VW   = (PW > IN_W) ? PW : IN_W;
    localparam int PVW  = PW + VW;
    localparam int PVW1 = PVW + 1;

    // Register file.
    logic [ENA_W-1:0] r_cfg_en;
    logic [CFG_W-1:0] r_cfg_base, r_cfg_min, r_cfg_max, r_cfg_inc, r_cfg_mna, r_cfg_mxa;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_en   <= '0;
            r_cfg_base <= '0;
            r_cfg_min  <= '0;
            r_cfg_max  <= '0;
            r_cfg_inc  <= '0;
            r_cfg_mna  <= '0;
            r_cfg_mxa  <= '0;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_HINT_EN: r_cfg_en   <= pwdata[ENA_W-1:0];
                REG_BASE:    r_cfg_base <= pwdata[CFG_W-1:0];
                REG_MIN:     r_cfg_min  <= pwdata[CFG_W-1:0];
                REG_MAX:     r_cfg_max  <= pwdata[CFG_W-1:0];
                REG_INC:     r_cfg_inc  <= pwdata[CFG_W-1:0];
                REG_MIN_ASP: r_cfg_mna  <= pwdata[CFG_W-1:0];
                REG_MAX_ASP: r_cfg_mxa  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_HINT_EN: prdata = 32'(r_cfg_en);
            REG_BASE:    prdata = 32'(r_cfg_base);
            REG_MIN:     prdata = 32'(r_cfg_min);
            REG_MAX:     prdata = 32'(r_cfg_max);
            REG_INC:     prdata = 32'(r_cfg_inc);
            REG_MIN_ASP: prdata = 32'(r_cfg_mna);
            REG_MAX_ASP: prdata = 32'(r_cfg_mxa);
            default:     prdata = '0;
        endcase
    end

    // Effective hints; the registers are to change only while the pipeline is empty, which the block does not enforce.
    function automatic logic [PW-1:0] f_lo(input logic [CFG_W-1:0] r);
        return PW'(r[SB-1:0]);
    endfunction

    function automatic logic [PW-1:0] f_hi(input logic [CFG_W-1:0] r);
        return PW'(r >> SB);
    endfunction

    function automatic logic [PW-1:0] f_one(input logic [PW-1:0] v);
        return (v == '0) ? PW'(1) : v;
    endfunction

    logic [PW-1:0] basew, baseh, minw, minh, maxw, maxh, xinc, yinc;
    logic [PW-1:0] bw_raw, bh_raw, mw_raw, mh_raw, nx, ny, xx, xy;
    logic          asp_on;

    always_comb begin
        bw_raw = r_cfg_en[EN_BASE] ? f_one(f_lo(r_cfg_base)) : PW'(1);
        bh_raw = r_cfg_en[EN_BASE] ? f_one(f_hi(r_cfg_base)) : PW'(1);
        mw_raw = r_cfg_en[EN_MIN]  ? f_one(f_lo(r_cfg_min))  : PW'(1);
        mh_raw = r_cfg_en[EN_MIN]  ? f_one(f_hi(r_cfg_min))  : PW'(1);
        basew  = (!r_cfg_en[EN_BASE] && r_cfg_en[EN_MIN]) ? mw_raw : bw_raw;
        baseh  = (!r_cfg_en[EN_BASE] && r_cfg_en[EN_MIN]) ? mh_raw : bh_raw;
        minw   = (r_cfg_en[EN_BASE] && !r_cfg_en[EN_MIN]) ? bw_raw : mw_raw;
        minh   = (r_cfg_en[EN_BASE] && !r_cfg_en[EN_MIN]) ? bh_raw : mh_raw;
        maxw   = r_cfg_en[EN_MAX] ? f_one(f_lo(r_cfg_max)) : PW'(DEFAULT_MAX);
        maxh   = r_cfg_en[EN_MAX] ? f_one(f_hi(r_cfg_max)) : PW'(DEFAULT_MAX);
        xinc   = r_cfg_en[EN_HINC] ? f_one(f_lo(r_cfg_inc)) : PW'(1);
        yinc   = r_cfg_en[EN_VINC] ? f_one(f_hi(r_cfg_inc)) : PW'(1);
        nx     = f_lo(r_cfg_mna);
        ny     = f_hi(r_cfg_mna);
        xx     = f_lo(r_cfg_mxa);
        xy     = f_hi(r_cfg_mxa);
        asp_on = r_cfg_en[EN_ASPECT] && (ny != '0) && (xx != '0);
    end

    logic en;
    logic r_out_vld;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    // Input and clamp stages.
    logic          r_v1, r_v2;
    logic [VW-1:0] r_w0, r_h0;
    logic [VW-1:0] r_wmag, r_hmag;
    logic          r_wneg, r_hneg;
    logic [VW-1:0] n_wc, n_hc;

    always_comb begin
        n_wc = (r_w0 < VW'(minw)) ? VW'(minw) : ((r_w0 > VW'(maxw)) ? VW'(maxw) : r_w0);
        n_hc = (r_h0 < VW'(minh)) ? VW'(minh) : ((r_h0 > VW'(maxh)) ? VW'(maxh) : r_h0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w0   <= VW'(s_axis_tdata[15:0]);
            r_h0   <= VW'(s_axis_tdata[31:16]);
            r_wneg <= n_wc < VW'(basew);
            r_hneg <= n_hc < VW'(baseh);
            r_wmag <= (n_wc < VW'(basew)) ? VW'(basew) - n_wc : n_wc - VW'(basew);
            r_hmag <= (n_hc < VW'(baseh)) ? VW'(baseh) - n_hc : n_hc - VW'(baseh);
        end
    end

    // Snap to base plus whole increments.
    logic            d1_vld;
    logic [VW-1:0]   d1_rem_unused, d2_quot_unused;
    logic [PW-1:0]   d1_rem, d2_rem;
    logic [2*VW+1:0] d1_side;
    logic [VW-1:0]   d1_wmag, d1_hmag;
    logic            d1_wneg, d1_hneg;

    wshc_div #(.DW(VW), .NW(PW), .SW(2*VW+2)) u_div_w (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v2),
        .i_dividend(r_wmag), .i_divisor(xinc),
        .i_side({r_wneg, r_hneg, r_wmag, r_hmag}),
        .o_valid(d1_vld), .o_quot(d1_rem_unused), .o_rem(d1_rem), .o_side(d1_side)
    );

    wshc_div #(.DW(VW), .NW(PW), .SW(1)) u_div_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v2),
        .i_dividend(r_hmag), .i_divisor(yinc), .i_side(1'b0),
        .o_valid(), .o_quot(d2_quot_unused), .o_rem(d2_rem), .o_side()
    );

    assign {d1_wneg, d1_hneg, d1_wmag, d1_hmag} = d1_side;

    logic          r_v3, r_v4, r_v5;
    logic [VW-1:0] r_wsn, r_hsn, r_w1, r_h1, r_w1c, r_h1c;
    logic          r_wneg3, r_hneg3;
    logic [PVW-1:0] r_a1, r_a2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wsn   <= d1_wmag - VW'(d1_rem);
            r_hsn   <= d1_hmag - VW'(d2_rem);
            r_wneg3 <= d1_wneg;
            r_hneg3 <= d1_hneg;
            r_w1    <= r_wneg3 ? VW'(basew) - r_wsn : VW'(basew) + r_wsn;
            r_h1    <= r_hneg3 ? VW'(baseh) - r_hsn : VW'(baseh) + r_hsn;
            r_a1    <= PVW'(nx) * PVW'(r_h1);
            r_a2    <= PVW'(r_w1) * PVW'(ny);
            r_w1c   <= r_w1;
            r_h1c   <= r_h1;
        end
    end

    // Minimum aspect rule.
    logic            d3_vld;
    logic [PVW-1:0]  d3_quot, d4_quot;
    logic [PW-1:0]   d3_rem_unused, d4_rem_unused;
    logic [2*VW:0]   d3_side;
    logic            d3_ca;
    logic [VW-1:0]   d3_w, d3_h;

    wshc_div #(.DW(PVW), .NW(PW), .SW(2*VW+1)) u_div_a2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v5),
        .i_dividend(r_a2), .i_divisor(nx),
        .i_side({asp_on && (r_a1 > r_a2), r_w1c, r_h1c}),
        .o_valid(d3_vld), .o_quot(d3_quot), .o_rem(d3_rem_unused), .o_side(d3_side)
    );

    wshc_div #(.DW(PVW), .NW(PW), .SW(1)) u_div_a1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v5),
        .i_dividend(r_a1), .i_divisor(ny), .i_side(1'b0),
        .o_valid(), .o_quot(d4_quot), .o_rem(d4_rem_unused), .o_side()
    );

    assign {d3_ca, d3_w, d3_h} = d3_side;

    logic           r_v7;
    logic [PVW-1:0] r_e1, r_e2;
    logic           r_ca7;
    logic [VW-1:0]  r_w7, r_h7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1  <= PVW'(d3_h) - d3_quot;
            r_e2  <= d4_quot - PVW'(d3_w);
            r_ca7 <= d3_ca;
            r_w7  <= d3_w;
            r_h7  <= d3_h;
        end
    end

    logic                    d5_vld;
    logic [PVW-1:0]          d5_quot_unused, d6_quot_unused;
    logic [PW-1:0]           d5_rem, d6_rem;
    logic [2*VW+2*PVW:0]     d5_side;
    logic                    d5_ca;
    logic [VW-1:0]           d5_w, d5_h;
    logic [PVW-1:0]          d5_e1, d5_e2;

    wshc_div #(.DW(PVW), .NW(PW), .SW(2*VW+2*PVW+1)) u_div_e1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v7),
        .i_dividend(r_e1), .i_divisor(yinc),
        .i_side({r_ca7, r_w7, r_h7, r_e1, r_e2}),
        .o_valid(d5_vld), .o_quot(d5_quot_unused), .o_rem(d5_rem), .o_side(d5_side)
    );

    wshc_div #(.DW(PVW), .NW(PW), .SW(1)) u_div_e2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v7),
        .i_dividend(r_e2), .i_divisor(xinc), .i_side(1'b0),
        .o_valid(), .o_quot(d6_quot_unused), .o_rem(d6_rem), .o_side()
    );

    assign {d5_ca, d5_w, d5_h, d5_e1, d5_e2} = d5_side;

    logic           r_v8, r_v9, r_v10;
    logic [PVW-1:0] r_m1, r_m2;
    logic           r_ca8;
    logic [VW-1:0]  r_w8, r_h8, r_w2, r_h2, r_w2c, r_h2c;
    logic [VW-1:0]  n_w2, n_h2;
    logic [PVW-1:0] r_b1, r_b2;

    always_comb begin
        n_w2 = r_w8;
        n_h2 = r_h8;
        if (r_ca8) begin
            if (PVW1'(r_h8) >= PVW1'(r_m1) + PVW1'(minh)) begin
                n_h2 = VW'(PVW'(r_h8) - r_m1);
            end else if ((r_m2 != '0) && (PVW1'(r_w8) + PVW1'(r_m2) <= PVW1'(maxw))) begin
                n_w2 = VW'(PVW'(r_w8) + r_m2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1  <= d5_e1 - PVW'(d5_rem);
            r_m2  <= d5_e2 - PVW'(d6_rem);
            r_ca8 <= d5_ca;
            r_w8  <= d5_w;
            r_h8  <= d5_h;
            r_w2  <= n_w2;
            r_h2  <= n_h2;
            r_b1  <= PVW'(r_w2) * PVW'(xy);
            r_b2  <= PVW'(xx) * PVW'(r_h2);
            r_w2c <= r_w2;
            r_h2c <= r_h2;
        end
    end

    // Maximum aspect rule.
    logic           d7_vld;
    logic [PVW-1:0] d7_quot, d8_quot;
    logic [PW-1:0]  d7_rem_unused, d8_rem_unused;
    logic [2*VW:0]  d7_side;
    logic           d7_cb;
    logic [VW-1:0]  d7_w, d7_h;

    wshc_div #(.DW(PVW), .NW(PW), .SW(2*VW+1)) u_div_b2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v10),
        .i_dividend(r_b2), .i_divisor(xy),
        .i_side({asp_on && (r_b1 > r_b2), r_w2c, r_h2c}),
        .o_valid(d7_vld), .o_quot(d7_quot), .o_rem(d7_rem_unused), .o_side(d7_side)
    );

    wshc_div #(.DW(PVW), .NW(PW), .SW(1)) u_div_b1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v10),
        .i_dividend(r_b1), .i_divisor(xx), .i_side(1'b0),
        .o_valid(), .o_quot(d8_quot), .o_rem(d8_rem_unused), .o_side()
    );

    assign {d7_cb, d7_w, d7_h} = d7_side;

    logic           r_v12;
    logic [PVW-1:0] r_f1, r_f2;
    logic           r_cb12;
    logic [VW-1:0]  r_w12, r_h12;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1   <= PVW'(d7_w) - d7_quot;
            r_f2   <= d8_quot - PVW'(d7_h);
            r_cb12 <= d7_cb;
            r_w12  <= d7_w;
            r_h12  <= d7_h;
        end
    end

    logic                d9_vld;
    logic [PVW-1:0]      d9_quot_unused, d10_quot_unused;
    logic [PW-1:0]       d9_rem, d10_rem;
    logic [2*VW+2*PVW:0] d9_side;
    logic                d9_cb;
    logic [VW-1:0]       d9_w, d9_h;
    logic [PVW-1:0]      d9_f1, d9_f2;

    wshc_div #(.DW(PVW), .NW(PW), .SW(2*VW+2*PVW+1)) u_div_f1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v12),
        .i_dividend(r_f1), .i_divisor(xinc),
        .i_side({r_cb12, r_w12, r_h12, r_f1, r_f2}),
        .o_valid(d9_vld), .o_quot(d9_quot_unused), .o_rem(d9_rem), .o_side(d9_side)
    );

    wshc_div #(.DW(PVW), .NW(PW), .SW(1)) u_div_f2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v12),
        .i_dividend(r_f2), .i_divisor(yinc), .i_side(1'b0),
        .o_valid(), .o_quot(d10_quot_unused), .o_rem(d10_rem), .o_side()
    );

    assign {d9_cb, d9_w, d9_h, d9_f1, d9_f2} = d9_side;

    logic             r_v13;
    logic [PVW-1:0]   r_m3, r_m4;
    logic             r_cb13;
    logic [VW-1:0]    r_w13, r_h13;
    logic [VW-1:0]    n_w3, n_h3;
    logic [OUT_W-1:0] r_gw, r_gh;

    always_comb begin
        n_w3 = r_w13;
        n_h3 = r_h13;
        if (r_cb13) begin
            if (PVW1'(r_w13) >= PVW1'(r_m3) + PVW1'(minw)) begin
                n_w3 = VW'(PVW'(r_w13) - r_m3);
            end else if ((r_m4 != '0) && (PVW1'(r_h13) + PVW1'(r_m4) <= PVW1'(maxh))) begin
                n_h3 = VW'(PVW'(r_h13) + r_m4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3   <= d9_f1 - PVW'(d9_rem);
            r_m4   <= d9_f2 - PVW'(d10_rem);
            r_cb13 <= d9_cb;
            r_w13  <= d9_w;
            r_h13  <= d9_h;
            r_gw   <= (n_w3 > VW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : n_w3[OUT_W-1:0];
            r_gh   <= (n_h3 > VW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : n_h3[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_v7      <= 1'b0;
            r_v8      <= 1'b0;
            r_v9      <= 1'b0;
            r_v10     <= 1'b0;
            r_v12     <= 1'b0;
            r_v13     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_v1      <= s_axis_tvalid;
            r_v2      <= r_v1;
            r_v3      <= d1_vld;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_v7      <= d3_vld;
            r_v8      <= d5_vld;
            r_v9      <= r_v8;
            r_v10     <= r_v9;
            r_v12     <= d7_vld;
            r_v13     <= d9_vld;
            r_out_vld <= r_v13;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_gh, r_gw};

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench of window_size_hint_constrainer_unit: writes hint settings over the
// register port and checks granted sizes against a built-in predictor.
// Depends on wshc_pkg and the RTL of the block.
module tb;
    import wshc_pkg::*;

    localparam int LATENCY = 156;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    // Bits 15:0 request_width, bits 31:16 request_height.
    logic [31:0] s_axis_tdata = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    // Bits 14:0 granted_width, bits 29:15 granted_height.
    logic [31:0] m_axis_tdata;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    typedef struct packed {
        logic [14:0] height;
        logic [14:0] width;
    } t_size;

    logic [ENA_W-1:0] hint_en;
    logic [CFG_W-1:0] base_r, min_r, max_r, inc_r, minasp_r, maxasp_r;

    t_size granted_q[$];
    int errors = 0;
    int words_out = 0;
    int idle_cycles = 0;
    bit long_stall = 0;
    bit stall_free = 0;

    window_size_hint_constrainer_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint lo16(logic [CFG_W-1:0] r);
        return longint'(r[15:0]);
    endfunction

    function automatic longint hi15(logic [CFG_W-1:0] r);
        return longint'(r[30:16]);
    endfunction

    function automatic longint one_up(longint v);
        return v < 1 ? 1 : v;
    endfunction

    function automatic longint snap(longint v, longint step);
        return (v / step) * step;
    endfunction

    function automatic logic [14:0] sat(longint v);
        if (v < 1) return 15'd1;
        if (v > OUT_MAX) return 15'(OUT_MAX);
        return 15'(v);
    endfunction

    function automatic t_size constrain(logic [15:0] rw, logic [15:0] rh);
        longint w, h, minw, minh, basew, baseh, xinc, yinc, maxw, maxh;
        longint nx, ny, xx, xy, d;
        t_size r;
        w = longint'(rw); h = longint'(rh);
        minw = 1; minh = 1; basew = 1; baseh = 1; xinc = 1; yinc = 1;
        maxw = DEFAULT_MAX; maxh = DEFAULT_MAX;
        if (hint_en[EN_BASE]) begin
            basew = one_up(lo16(base_r)); baseh = one_up(hi15(base_r));
        end
        if (hint_en[EN_MIN]) begin
            minw = one_up(lo16(min_r)); minh = one_up(hi15(min_r));
        end
        if (hint_en[EN_BASE] && !hint_en[EN_MIN]) begin
            minw = basew; minh = baseh;
        end
        if (hint_en[EN_MIN] && !hint_en[EN_BASE]) begin
            basew = minw; baseh = minh;
        end
        if (hint_en[EN_MAX]) begin
            maxw = one_up(lo16(max_r)); maxh = one_up(hi15(max_r));
        end
        if (hint_en[EN_HINC]) xinc = one_up(lo16(inc_r));
        if (hint_en[EN_VINC]) yinc = one_up(hi15(inc_r));
        w = w < minw ? minw : (w > maxw ? maxw : w);
        h = h < minh ? minh : (h > maxh ? maxh : h);
        w = basew + snap(w - basew, xinc);
        h = baseh + snap(h - baseh, yinc);
        nx = lo16(minasp_r); ny = hi15(minasp_r);
        xx = lo16(maxasp_r); xy = hi15(maxasp_r);
        if (hint_en[EN_ASPECT] && ny > 0 && xx > 0) begin
            if (nx * h > w * ny) begin
                d = snap(h - (w * ny) / nx, yinc);
                if (h - d >= minh) h -= d;
                else begin
                    d = snap((h * nx) / ny - w, xinc);
                    if (d > 0 && w + d <= maxw) w += d;
                end
            end
            if (w * xy > xx * h) begin
                d = snap(w - (h * xx) / xy, xinc);
                if (w - d >= minw) w -= d;
                else if (xy > 0) begin
                    d = snap((w * xy) / xx - h, yinc);
                    if (d > 0 && h + d <= maxh) h += d;
                end
            end
        end
        r.width = sat(w);
        r.height = sat(h);
        return r;
    endfunction

    task automatic report(string what, logic [14:0] got, logic [14:0] exp);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
    endtask

    always @(posedge i_clk) begin
        t_size got, exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[29:0];
            words_out++;
            if (granted_q.size() == 0) begin
                errors++;
                $display("unexpected word %h", m_axis_tdata);
            end else begin
                exp = granted_q.pop_front();
                if (got.width != exp.width) report("width", got.width, exp.width);
                if (got.height != exp.height) report("height", got.height, exp.height);
            end
        end
    end

    // Receiver: mostly random stalls, sometimes none, one long hold-off per random run.
    always @(posedge i_clk) begin
        int hold;
        if (long_stall) begin
            m_axis_tready <= 0;
            hold = 0;
            while (hold < 400) begin
                @(posedge i_clk);
                hold++;
            end
            long_stall = 0;
        end else if (stall_free) m_axis_tready <= 1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_HINT_EN: hint_en = val[ENA_W-1:0];
            REG_BASE: base_r = val[CFG_W-1:0];
            REG_MIN: min_r = val[CFG_W-1:0];
            REG_MAX: max_r = val[CFG_W-1:0];
            REG_INC: inc_r = val[CFG_W-1:0];
            REG_MIN_ASP: minasp_r = val[CFG_W-1:0];
            REG_MAX_ASP: maxasp_r = val[CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [5:0] en, logic [31:0] b, logic [31:0] mn,
                             logic [31:0] mx, logic [31:0] inc, logic [31:0] na,
                             logic [31:0] xa);
        write_reg(REG_HINT_EN, 32'(en));
        write_reg(REG_BASE, b);
        write_reg(REG_MIN, mn);
        write_reg(REG_MAX, mx);
        write_reg(REG_INC, inc);
        write_reg(REG_MIN_ASP, na);
        write_reg(REG_MAX_ASP, xa);
    endtask

    task automatic send_request(logic [15:0] w, logic [15:0] h);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {h, w};
        granted_q.push_back(constrain(w, h));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic pause_random();
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (granted_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pair(int maxv);
        return {1'b0, 15'($urandom_range(0, maxv)), 16'($urandom_range(0, maxv))};
    endfunction

    task automatic test_extremes();
        write_all(6'h3F, 32'h0004_0003, 32'h000A_0008, 32'h7FFF_FFFF, 32'h0005_0007,
                  32'h0001_0001, 32'h0001_0002);
        send_request(16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000);
        send_request(16'h0000, 16'hFFFF);
        send_request(16'h5555, 16'hAAAA);
        send_request(16'hAAAA, 16'h5555);
        drain();
        // All hints off, then base, min and max with large values so sides saturate.
        write_all(6'h00, 0, 0, 0, 0, 0, 0);
        send_request(16'hFFFF, 16'h0001);
        send_request(16'd0, 16'd40000);
        drain();
        write_all(6'h07, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        send_request(16'd100, 16'd100);
        send_request(16'hFFFF, 16'hFFFF);
        drain();
    endtask

    task automatic test_aspect_cases();
        // Zero minimum x, zero maximum y, grow branches near limits.
        write_all(6'h24, 0, 0, 32'h0064_0064, 0, 32'h0001_0000, 32'h0003_0001);
        send_request(16'd10, 16'd90);
        send_request(16'd90, 16'd10);
        drain();
        write_all(6'h20, 0, 0, 0, 0, 32'h0002_0001, 32'h0000_0001);
        send_request(16'd10, 16'd90);
        drain();
        write_all(6'h3E, 0, 32'h0032_0032, 32'h0064_0064, 32'h0003_0003,
                  32'h0001_0003, 32'h0003_0001);
        send_request(16'd60, 16'd99);
        send_request(16'd99, 16'd60);
        send_request(16'd55, 16'd55);
        drain();
    endtask

    task automatic test_random(int n, bit wide);
        int i, k;
        logic [31:0] v;
        for (k = 0; k < 6; k++) begin
            if (k == 5) stall_free = 1;
            v = wide ? $urandom() : rand_pair(200);
            write_all(6'($urandom_range(0, 63)), $urandom_range(0, 3) == 0 ? $urandom() : v,
                      rand_pair(wide ? 40000 : 150), rand_pair(wide ? 65535 : 400),
                      rand_pair(wide ? 65535 : 12), rand_pair(wide ? 65535 : 9),
                      rand_pair(wide ? 65535 : 9));
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 2) == 0)
                    send_request(16'($urandom()), 16'($urandom()));
                else
                    send_request(16'($urandom_range(0, 500)), 16'($urandom_range(0, 500)));
                if (i == n / 2 && k == 1) long_stall = 1;
                if ($urandom_range(0, 5) == 0) pause_random();
            end
            drain();
            stall_free = 0;
        end
    endtask

    initial begin
        hint_en = 0; base_r = 0; min_r = 0; max_r = 0; inc_r = 0;
        minasp_r = 0; maxasp_r = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        test_extremes();
        test_aspect_cases();
        test_random(200, 0);
        test_random(100, 1);
        $display("Run covered directed extremes, aspect cases and %0d result words", words_out);
        $display("across random hint settings with sender gaps and receiver stalls.");
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

### files.f
rtl/wshc_pkg.sv
rtl/wshc_div.sv
rtl/window_size_hint_constrainer_unit.sv
tb/tb.sv
